FILE: hdl/csrmv_pkg.sv
package csrmv_pkg;

  // Item kinds on the input channel
  typedef enum logic [1:0] {
    KIND_LOAD    = 2'd0,
    KIND_NONZERO = 2'd1,
    KIND_EMPTY   = 2'd2
  } kind_t;

  // Configuration register indexes
  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] REG_ALPHA_GAIN = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_BETA_GAIN  = 2'd1;

  localparam logic signed [31:0] ALPHA_RESET = 32'sd65536;
  localparam logic signed [31:0] BETA_RESET  = 32'sd0;

  localparam logic signed [31:0] Y_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [31:0] Y_MIN = 32'sh8000_0000;
  localparam logic signed [63:0] SUM_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;
  localparam logic signed [63:0] SUM_MIN = 64'sh8000_0000_0000_0000;

  // Half an output LSB in Q48.48, for round half up
  localparam logic [95:0] ROUND_HALF = 96'h8000_0000;

  typedef struct packed {
    kind_t              kind;
    logic [9:0]         position;
    logic signed [31:0] value;
    logic               row_last;
    logic signed [31:0] prior_y;
  } in_item_t;

  typedef struct packed {
    logic [15:0]        row_index;
    logic signed [31:0] result_y;
    logic               saturated;
  } out_item_t;

  // Sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_ACC,
    ST_F_LO,
    ST_F_HI,
    ST_F_B,
    ST_F_ADD,
    ST_RES
  } state_t;

endpackage

FILE: hdl/csr_sparse_matvec_axpby.sv
// CSR sparse matrix-vector unit: y = alpha*A*x + beta*y, Q16.16 values.
// Input channel (in_valid/in_ready/in_item) carries one item per handshake:
//   load items write x[position] and restart the row count; nonzero items
//   multiply value by the stored x entry into a saturating Q32.32 row sum;
//   the nonzero flagged row_last, or an empty-row item, finishes the row.
// Output channel (out_valid/out_ready/out_item) gives one result per row:
//   row index since the last load, rounded and saturated alpha*sum +
//   beta*prior_y, and a flag if the sum or the result was clipped.
// Config channel (cfg_valid/cfg_ready/cfg_index/cfg_data) writes alpha_gain
//   and beta_gain; it is always ready and should be used only while idle.
// Flow: one item is worked on at a time, all through one shared 33x33
//   multiplier and the x store's registered read port. A load is done as it
//   is taken; a nonzero passes read, multiply and accumulate, and if it ends
//   a row, or for an empty-row item, the four finishing steps (alpha*low sum,
//   alpha*high sum, beta*prior_y, final add) follow, then the result step,
//   which loads the result into the output register.
// Stall: a result waits in the output register while the next items are
//   taken; a further row end holds in its last step until that result goes.
// Reset: gains return to 1.0 and 0, row sum and row count clear, no result
//   is pending; the x store is not cleared and must be loaded before use.
module csr_sparse_matvec_axpby
  import csrmv_pkg::*;
#(
  parameter int X_DEPTH  = 1024,
  parameter int MAX_ROWS = 65536
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  in_item_t             in_item,
  output logic                 out_valid,
  input  logic                 out_ready,
  output out_item_t            out_item,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [31:0]          cfg_data
);

  localparam int AW  = $clog2(X_DEPTH);
  localparam int RCW = $clog2(MAX_ROWS);

  state_t state, state_next;

  logic signed [31:0] alpha_gain;
  logic signed [31:0] beta_gain;

  logic [31:0] x_mem [X_DEPTH];
  logic [31:0] x_rd;

  logic [31:0]   pos_ext;
  logic [AW-1:0] x_addr;
  logic          pos_ok;
  logic          in_fire;
  logic          out_load;

  // Item held while it is worked on
  logic signed [31:0] value_q;
  logic signed [31:0] prior_q;
  logic               last_q;
  logic               range_q;

  logic signed [63:0] row_sum;
  logic               sum_clipped;
  logic [RCW-1:0]     row_count;
  logic [31:0]        row_count_ext;

  logic signed [32:0] mul_a;
  logic signed [32:0] mul_b;
  logic signed [65:0] mul_p;
  logic [63:0]        mq;
  logic [95:0]        acc;

  logic [64:0]        sum_ext;
  logic               sum_ovf;
  logic [63:0]        q;
  logic               res_hi;
  logic               res_lo;
  logic signed [31:0] res_y;

  assign cfg_ready     = 1'b1;
  assign in_fire       = in_valid && in_ready;
  assign pos_ext       = 32'(in_item.position);
  assign pos_ok        = pos_ext < 32'(X_DEPTH);
  assign x_addr        = pos_ext[AW-1:0];
  assign row_count_ext = 32'(row_count);

  // Gain registers
  always_ff @(posedge clk) begin
    if (rst) begin
      alpha_gain <= ALPHA_RESET;
      beta_gain  <= BETA_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_ALPHA_GAIN: alpha_gain <= cfg_data;
        REG_BETA_GAIN:  beta_gain  <= cfg_data;
        default: ;
      endcase
    end
  end

  // x store: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (in_fire && in_item.kind == KIND_LOAD && pos_ok) begin
      x_mem[x_addr] <= in_item.value;
    end
    x_rd <= x_mem[x_addr];
  end

  // Sequencer state
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    in_ready   = 1'b0;
    out_load   = 1'b0;
    case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          case (in_item.kind)
            KIND_NONZERO: state_next = ST_MUL;
            KIND_EMPTY:   state_next = ST_F_LO;
            default:      state_next = ST_IDLE;
          endcase
        end
      end
      ST_MUL:   state_next = ST_ACC;
      ST_ACC:   state_next = last_q ? ST_F_LO : ST_IDLE;
      ST_F_LO:  state_next = ST_F_HI;
      ST_F_HI:  state_next = ST_F_B;
      ST_F_B:   state_next = ST_F_ADD;
      ST_F_ADD: state_next = ST_RES;
      ST_RES: begin
        if (!out_valid || out_ready) begin
          out_load   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // Shared multiplier operand select
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state)
      ST_MUL: begin
        mul_a = 33'(value_q);
        mul_b = range_q ? 33'(signed'(x_rd)) : '0;
      end
      ST_F_LO: begin
        mul_a = 33'(alpha_gain);
        mul_b = signed'({1'b0, row_sum[31:0]});
      end
      ST_F_HI: begin
        mul_a = 33'(alpha_gain);
        mul_b = 33'(signed'(row_sum[63:32]));
      end
      ST_F_B: begin
        mul_a = 33'(beta_gain);
        mul_b = 33'(prior_q);
      end
      default: ;
    endcase
  end

  assign mul_p = mul_a * mul_b;

  // Saturating row-sum add
  assign sum_ext = {row_sum[63], row_sum} + {mq[63], mq};
  assign sum_ovf = sum_ext[64] != sum_ext[63];

  // Result rounding already folded in; clip Q16.16 to 32 bits
  assign q      = acc[95:32];
  assign res_hi = !q[63] && (|q[62:31]);
  assign res_lo = q[63] && !(&q[62:31]);
  always_comb begin
    if (res_hi) begin
      res_y = Y_MAX;
    end else if (res_lo) begin
      res_y = Y_MIN;
    end else begin
      res_y = q[31:0];
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    mq <= mul_p[63:0];
    if (in_fire) begin
      value_q <= in_item.value;
      prior_q <= in_item.prior_y;
      last_q  <= in_item.row_last;
      range_q <= pos_ok;
    end
    case (state)
      ST_F_HI:  acc <= {{32{mq[63]}}, mq} + ROUND_HALF;
      ST_F_B:   acc <= acc + {mq, 32'd0};
      ST_F_ADD: acc <= acc + {{16{mq[63]}}, mq, 16'd0};
      default: ;
    endcase
  end

  // Row state: sum, clip flag, row count
  always_ff @(posedge clk) begin
    if (rst) begin
      row_sum     <= '0;
      sum_clipped <= 1'b0;
      row_count   <= '0;
    end else begin
      if (in_fire && in_item.kind == KIND_LOAD) begin
        row_sum     <= '0;
        sum_clipped <= 1'b0;
        row_count   <= '0;
      end else if (in_fire && in_item.kind == KIND_EMPTY) begin
        row_sum     <= '0;
        sum_clipped <= 1'b0;
      end else if (state == ST_ACC) begin
        if (sum_ovf) begin
          row_sum     <= mq[63] ? SUM_MIN : SUM_MAX;
          sum_clipped <= 1'b1;
        end else begin
          row_sum <= sum_ext[63:0];
        end
      end else if (out_load) begin
        row_sum     <= '0;
        sum_clipped <= 1'b0;
        if (row_count == RCW'(MAX_ROWS - 1)) begin
          row_count <= '0;
        end else begin
          row_count <= row_count + 1'b1;
        end
      end
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_item.row_index <= row_count_ext[15:0];
      out_item.result_y  <= res_y;
      out_item.saturated <= sum_clipped || res_hi || res_lo;
    end
  end

  // Checks
  a_load_clears_count: assert property (@(posedge clk) disable iff (rst)
    (in_fire && in_item.kind == KIND_LOAD) |=> (row_count == '0))
    else $error("row count not cleared by load");

  a_nonzero_reads: assert property (@(posedge clk) disable iff (rst)
    (in_fire && in_item.kind == KIND_NONZERO) |=> (state == ST_MUL))
    else $error("nonzero item did not start a multiply");

  a_res_holds: assert property (@(posedge clk) disable iff (rst)
    (state == ST_RES && out_valid && !out_ready) |=> (state == ST_RES))
    else $error("pending result overwritten");

  a_res_index: assert property (@(posedge clk) disable iff (rst)
    out_load |=> (out_valid && out_item.row_index == $past(row_count_ext[15:0])))
    else $error("result row index mismatch");

endmodule

FILE: test/csr_sparse_matvec_axpby_tb.sv
module csr_sparse_matvec_axpby_tb;
  import csrmv_pkg::*;

  // Kind code that the block must ignore
  localparam kind_t KIND_SPARE = kind_t'(2'd3);
  // Register index with no register behind it
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;
  localparam logic signed [31:0] GAIN_ONE = 32'sh0001_0000;
  localparam int CYCLE_LIMIT = 2_000_000;
  localparam int RANDOM_ITEMS = 1800;
  localparam int PHASES = 8;
  localparam int SETTLE = 20;

  typedef struct packed {
    logic      on;
    out_item_t y;
  } pin_t;

  typedef struct packed {
    in_item_t  item;
    logic      pinned;
    out_item_t y;
  } plan_row_t;

  logic      clk = 1'b0;
  logic      rst = 1'b1;
  logic      in_valid = 1'b0;
  logic      in_ready;
  in_item_t  in_item = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  out_item_t out_item;
  logic      cfg_valid = 1'b0;
  logic      cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [31:0] cfg_data = '0;

  csr_sparse_matvec_axpby dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_item  (out_item),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #5 clk = ~clk;

  // Own copy of the block's state
  logic signed [31:0] xs [0:1023];
  logic signed [63:0] sum_q = '0;
  logic               sum_clip = 1'b0;
  logic [15:0]        row_no = '0;
  logic signed [31:0] gain_a = ALPHA_RESET;
  logic signed [31:0] gain_b = BETA_RESET;

  out_item_t pending_rows [$];
  pin_t      pin_q [$];

  // Stimulus bookkeeping
  bit        loaded [0:1023];
  logic [9:0] loaded_list [$];
  int        sent_items = 0;
  int        burst_left = 0;
  bit        tx_free = 1'b0;
  bit        rx_free = 1'b0;
  logic [12:0] rx_pattern = 13'h1;
  int        rx_phase = 0;

  int errors = 0;
  int accepted = 0;
  int rows_seen = 0;
  int gain_writes = 0;
  int cycles = 0;

  // Finished row: alpha*sum + beta*prior in Q48.48, round half up, clip to Q16.16
  function automatic out_item_t row_result(input logic signed [63:0] sum, input logic clip,
                                           input logic signed [31:0] prior);
    logic signed [127:0] a, s, b, p, acc, q;
    out_item_t r;
    a = 128'(gain_a);
    s = 128'(sum);
    b = 128'(gain_b);
    p = 128'(prior);
    acc = a * s + ((b * p) <<< 16) + $signed({32'd0, ROUND_HALF});
    q = acc >>> 32;
    r.row_index = row_no;
    if (q > 128'(Y_MAX)) begin
      r.result_y = Y_MAX;
      clip = 1'b1;
    end else if (q < 128'(Y_MIN)) begin
      r.result_y = Y_MIN;
      clip = 1'b1;
    end else begin
      r.result_y = q[31:0];
    end
    r.saturated = clip;
    return r;
  endfunction

  // Works out what one accepted item does to the state and what it emits
  task automatic matvec_step(input in_item_t item, output bit emits, output out_item_t y);
    logic signed [63:0] prod;
    logic signed [64:0] total;
    emits = 1'b0;
    y = '0;
    case (item.kind)
      KIND_LOAD: begin
        xs[item.position] = item.value;
        sum_q = '0;
        sum_clip = 1'b0;
        row_no = '0;
      end
      KIND_NONZERO: begin
        prod = 64'(item.value) * 64'(xs[item.position]);
        total = 65'(sum_q) + 65'(prod);
        if (total > 65'(SUM_MAX)) begin
          sum_q = SUM_MAX;
          sum_clip = 1'b1;
        end else if (total < 65'(SUM_MIN)) begin
          sum_q = SUM_MIN;
          sum_clip = 1'b1;
        end else begin
          sum_q = total[63:0];
        end
        if (item.row_last) begin
          y = row_result(sum_q, sum_clip, item.prior_y);
          emits = 1'b1;
          row_no = row_no + 16'd1;
          sum_q = '0;
          sum_clip = 1'b0;
        end
      end
      KIND_EMPTY: begin
        // partial sum is thrown away
        sum_q = '0;
        sum_clip = 1'b0;
        y = row_result('0, 1'b0, item.prior_y);
        emits = 1'b1;
        row_no = row_no + 16'd1;
      end
      default: ;
    endcase
  endtask

  function automatic void note_mismatch(input string field, input logic [63:0] want,
                                        input logic [63:0] got);
    errors++;
    if (errors <= 40)
      $display("%0t: %s expected %h, got %h", $time, field, want, got);
  endfunction

  // Check results, then predict from accepted items and gain writes
  always @(posedge clk) begin : watch
    out_item_t want, y;
    pin_t      pin;
    bit        emits;
    if (rst) begin
      gain_a = ALPHA_RESET;
      gain_b = BETA_RESET;
      sum_q = '0;
      sum_clip = 1'b0;
      row_no = '0;
    end else begin
      if (out_valid && out_ready) begin
        if (pending_rows.size() == 0) begin
          note_mismatch("unexpected result, row/y", {16'd0, out_item.row_index, 32'd0},
                        {16'd0, out_item.row_index, out_item.result_y});
        end else begin
          want = pending_rows.pop_front();
          rows_seen++;
          if (out_item.row_index !== want.row_index)
            note_mismatch("row_index", 64'(want.row_index), 64'(out_item.row_index));
          if (out_item.result_y !== want.result_y)
            note_mismatch("result_y", 64'(want.result_y), 64'(out_item.result_y));
          if (out_item.saturated !== want.saturated)
            note_mismatch("saturated", 64'(want.saturated), 64'(out_item.saturated));
        end
      end
      if (in_valid && in_ready) begin
        accepted++;
        pin = pin_q.pop_front();
        matvec_step(in_item, emits, y);
        if (emits)
          pending_rows.push_back(pin.on ? pin.y : y);
      end
      if (cfg_valid && cfg_ready) begin
        gain_writes++;
        case (cfg_index)
          REG_ALPHA_GAIN: gain_a = cfg_data;
          REG_BETA_GAIN:  gain_b = cfg_data;
          default: ;
        endcase
      end
    end
  end

  // Receiver: rotating stall pattern, reloaded each turn
  always @(posedge clk) begin
    if (rx_free) begin
      out_ready <= 1'b1;
    end else begin
      out_ready <= rx_pattern[rx_phase];
    end
    if (rx_phase == 12) begin
      rx_phase <= 0;
      rx_pattern <= 13'($urandom) | 13'd1;
    end else begin
      rx_phase <= rx_phase + 1;
    end
  end

  // Run limit
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  function automatic logic signed [31:0] rand_q16();
    case ($urandom_range(0, 9))
      0: return Y_MAX;
      1: return Y_MIN;
      2, 3: return $urandom;
      4, 5: return $signed($urandom_range(0, 32'h0200_0000)) - 32'sh0100_0000;
      default: return $signed($urandom_range(0, 32'h0008_0000)) - 32'sh0004_0000;
    endcase
  endfunction

  // Sender: bursts of items with random gaps between them
  task automatic push_item(input in_item_t item, input logic pinned = 1'b0,
                           input out_item_t pin_y = '0);
    if (burst_left == 0) begin
      if (!tx_free) begin
        in_valid <= 1'b0;
        repeat ($urandom_range(1, 9)) @(posedge clk);
      end
      burst_left = $urandom_range(1, 24);
    end
    if (item.kind == KIND_LOAD && !loaded[item.position]) begin
      loaded[item.position] = 1'b1;
      loaded_list.push_back(item.position);
    end
    if (item.kind != KIND_SPARE)
      sent_items++;
    pin_q.push_back({pinned, pin_y});
    in_valid <= 1'b1;
    in_item <= item;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    burst_left--;
  endtask

  task automatic load_x(input int n);
    in_item_t item;
    repeat (n) begin
      item.kind = KIND_LOAD;
      item.position = 10'($urandom);
      item.value = rand_q16();
      item.row_last = 1'($urandom);
      item.prior_y = $urandom;
      push_item(item);
    end
  endtask

  // n nonzeros on loaded columns; an empty-row item when n is zero and the row closes
  task automatic emit_row(input int n, input bit close);
    in_item_t item;
    item.position = '0;
    item.value = $urandom;
    item.prior_y = rand_q16();
    item.row_last = 1'($urandom);
    if (n == 0) begin
      item.kind = KIND_EMPTY;
      if (close)
        push_item(item);
    end
    for (int i = 0; i < n; i++) begin
      item.kind = KIND_NONZERO;
      item.position = loaded_list[$urandom_range(0, loaded_list.size() - 1)];
      item.value = rand_q16();
      item.row_last = close && (i == n - 1);
      item.prior_y = rand_q16();
      push_item(item);
    end
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (pending_rows.size() != 0) @(posedge clk);
    // loads and open rows leave no result, give them time to finish
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_gain(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
  endtask

  task automatic set_gains(input logic signed [31:0] a, input logic signed [31:0] b,
                           input bit poke_unused);
    write_gain(REG_ALPHA_GAIN, a);
    write_gain(REG_BETA_GAIN, b);
    if (poke_unused)
      write_gain(REG_UNUSED, $urandom);
    cfg_valid <= 1'b0;
  endtask

  function automatic plan_row_t row_of(input kind_t k, input logic [9:0] pos,
                                       input logic [31:0] val, input logic last,
                                       input logic [31:0] prior, input logic pin,
                                       input logic [15:0] idx, input logic [31:0] y,
                                       input logic sat);
    plan_row_t r;
    r.item.kind = k;
    r.item.position = pos;
    r.item.value = val;
    r.item.row_last = last;
    r.item.prior_y = prior;
    r.pinned = pin;
    r.y.row_index = idx;
    r.y.result_y = y;
    r.y.saturated = sat;
    return r;
  endfunction

  initial begin
    plan_row_t plan [$];
    logic signed [31:0] a, b;
    int target;

    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // Directed items at reset gains (alpha 1.0, beta 0)
    // empty row first, beta zero so prior_y has no say
    plan.push_back(row_of(KIND_EMPTY, 10'd0, 32'h0, 1'b0, Y_MAX, 1'b1, 16'd0, 32'h0, 1'b0));
    plan.push_back(row_of(KIND_LOAD, 10'd0, 32'h0001_0000, 1'b0, 32'h0, 1'b0, 0, 0, 0));
    plan.push_back(row_of(KIND_LOAD, 10'd1023, Y_MIN, 1'b1, 32'h1234_5678, 1'b0, 0, 0, 0));
    plan.push_back(row_of(KIND_LOAD, 10'd1, Y_MAX, 1'b0, 32'h0, 1'b0, 0, 0, 0));
    plan.push_back(row_of(KIND_LOAD, 10'd2, 32'h0002_0000, 1'b0, 32'h0, 1'b0, 0, 0, 0));
    // 3.0 * 1.0
    plan.push_back(row_of(KIND_NONZERO, 10'd0, 32'h0003_0000, 1'b1, 32'h0, 1'b1,
                          16'd0, 32'h0003_0000, 1'b0));
    // 1.5 * 2.0 - 1.0 * 1.0
    plan.push_back(row_of(KIND_NONZERO, 10'd2, 32'h0001_8000, 1'b0, 32'h0, 1'b0, 0, 0, 0));
    plan.push_back(row_of(KIND_NONZERO, 10'd0, 32'hFFFF_0000, 1'b1, Y_MIN, 1'b1,
                          16'd1, 32'h0002_0000, 1'b0));
    plan.push_back(row_of(KIND_EMPTY, 10'd0, 32'h0, 1'b0, Y_MIN, 1'b1, 16'd2, 32'h0, 1'b0));
    // row sum clips high, then low
    plan.push_back(row_of(KIND_NONZERO, 10'd1023, Y_MIN, 1'b0, 32'h0, 1'b0, 0, 0, 0));
    plan.push_back(row_of(KIND_NONZERO, 10'd1023, Y_MIN, 1'b1, 32'h0, 1'b1,
                          16'd3, Y_MAX, 1'b1));
    plan.push_back(row_of(KIND_NONZERO, 10'd1023, Y_MAX, 1'b0, 32'h0, 1'b0, 0, 0, 0));
    plan.push_back(row_of(KIND_NONZERO, 10'd1023, Y_MAX, 1'b0, 32'h0, 1'b0, 0, 0, 0));
    plan.push_back(row_of(KIND_NONZERO, 10'd1023, Y_MAX, 1'b1, 32'h0, 1'b1,
                          16'd4, Y_MIN, 1'b1));
    // load part way through a row restarts the sum and the count
    plan.push_back(row_of(KIND_NONZERO, 10'd1, Y_MAX, 1'b0, 32'h0, 1'b0, 0, 0, 0));
    plan.push_back(row_of(KIND_LOAD, 10'd5, 32'h0000_0001, 1'b0, 32'h0, 1'b0, 0, 0, 0));
    plan.push_back(row_of(KIND_NONZERO, 10'd5, 32'h0000_0001, 1'b1, 32'h0, 1'b0, 0, 0, 0));
    // empty row drops a partial sum
    plan.push_back(row_of(KIND_NONZERO, 10'd0, 32'h0000_8000, 1'b0, 32'h0, 1'b0, 0, 0, 0));
    plan.push_back(row_of(KIND_EMPTY, 10'd0, 32'h0, 1'b0, 32'h0001_0000, 1'b1,
                          16'd1, 32'h0, 1'b0));
    plan.push_back(row_of(KIND_SPARE, 10'd1023, 32'hFFFF_FFFF, 1'b1, 32'hFFFF_FFFF,
                          1'b0, 0, 0, 0));
    // result clips with no clip in the sum
    plan.push_back(row_of(KIND_NONZERO, 10'd1, Y_MAX, 1'b1, 32'h0, 1'b1,
                          16'd2, Y_MAX, 1'b1));
    plan.push_back(row_of(KIND_NONZERO, 10'd0, 32'h0, 1'b1, 32'h0, 1'b1, 16'd3, 32'h0, 1'b0));
    // rounding of the smallest products, both signs
    plan.push_back(row_of(KIND_NONZERO, 10'd0, 32'h0000_0001, 1'b1, 32'h0, 1'b0, 0, 0, 0));
    plan.push_back(row_of(KIND_NONZERO, 10'd0, 32'hFFFF_FFFF, 1'b1, 32'h0, 1'b0, 0, 0, 0));

    foreach (plan[i])
      push_item(plan[i].item, plan[i].pinned, plan[i].y);

    // Random phases, each with its own gains and idling
    for (int ph = 0; ph < PHASES; ph++) begin
      drain();
      case (ph)
        0: begin a = Y_MAX;     b = Y_MIN;    end
        1: begin a = Y_MIN;     b = Y_MAX;    end
        2: begin a = '0;        b = GAIN_ONE; end
        3: begin a = GAIN_ONE;  b = '0;       end
        4: begin a = -GAIN_ONE; b = GAIN_ONE; end
        default: begin a = rand_q16(); b = rand_q16(); end
      endcase
      set_gains(a, b, ph == 5);
      tx_free = (ph % 4 == 3);
      rx_free <= (ph % 4 == 2);
      load_x($urandom_range(1, 24));
      target = sent_items + RANDOM_ITEMS / PHASES;
      while (sent_items < target) begin
        case ($urandom_range(0, 19))
          0: begin
            emit_row(0, 1'b0);
            push_item({KIND_SPARE, 10'($urandom), 32'($urandom), 1'($urandom),
                       32'($urandom)});
          end
          1: load_x($urandom_range(1, 4));
          2: begin
            emit_row($urandom_range(1, 3), 1'b0);
            emit_row(0, 1'b1);
          end
          3: begin
            emit_row($urandom_range(1, 3), 1'b0);
            load_x(1);
          end
          default: emit_row($urandom_range(0, 6), 1'b1);
        endcase
      end
    end

    drain();
    $display("%0d items accepted, %0d results checked, %0d register writes;",
             accepted, rows_seen, gain_writes);
    $display("directed corners, then %0d random phases with their own gains and idling",
             PHASES);
    if (errors == 0)
      $display("SUCCESS");
    else
      $display("FAILURE");
    $finish;
  end

endmodule
